// File: hdl/cfud_pkg.sv
`timescale 1ns / 1ps

package cfud_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hAB;
    localparam logic [7:0] SYNC_SECOND  = 8'hCD;
    localparam logic [3:0] STAMP_BYTES  = 4'd8;
    localparam logic [3:0] IDENT_BYTES  = 4'd4;
    localparam logic [3:0] LANE_LIMIT   = 4'd8;
    localparam int         MAX_DATA_BYTES_DEF = 8;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    typedef struct packed {
        logic        frame_status;
        logic [63:0] time_stamp;
        logic [31:0] identifier;
        logic        remote_request;
        logic        extended_id;
        logic [3:0]  data_length;
        logic [63:0] payload;
    } t_result;

endpackage

// File: hdl/can_frame_uart_deframer_unit.sv
// Byte-stream deframer: hunts for the sync pair AB CD, then gathers an 8-byte
// timestamp, a 4-byte identifier, a flag byte, a length byte and up to
// MAX_DATA_BYTES data bytes, all little-endian, and emits one message beat.
// Input channel: one received byte per beat (i_in_valid / o_in_ready).
// Output channel: one frame beat per message (o_out_valid / i_out_ready),
// frame_status 1 marks a dropped frame whose length code was too large.
// The last byte of the frame (length byte for empty or bad frames) passes
// from the input holding register through the frame state update into the
// result register, which drives o_out_valid.
// Throughput: one byte per cycle while the result register is free, set
// by the frame state update between the holding and result registers.
// When the receiver stalls, the result register holds, the state update
// pauses, the holding register fills and then o_in_ready drops.
// Reset clears both valid flags and puts the block back to sync hunting.
`timescale 1ns / 1ps

module can_frame_uart_deframer_unit
    import cfud_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_status,
    output logic [63:0] o_time_stamp,
    output logic [31:0] o_identifier,
    output logic        o_remote_request,
    output logic        o_extended_id,
    output logic [3:0]  o_data_length,
    output logic [63:0] o_payload
);

    logic       byte_valid;
    logic [7:0] byte_q;
    logic       slot_free;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign fire = byte_valid && slot_free;

    cfud_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_take       (fire),
        .o_byte_valid (byte_valid),
        .o_byte       (byte_q)
    );

    cfud_core #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (byte_q),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfud_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_frame_status   = out_res.frame_status;
    assign o_time_stamp     = out_res.time_stamp;
    assign o_identifier     = out_res.identifier;
    assign o_remote_request = out_res.remote_request;
    assign o_extended_id    = out_res.extended_id;
    assign o_data_length    = out_res.data_length;
    assign o_payload        = out_res.payload;

endmodule

// File: hdl/cfud_in_stage.sv
`timescale 1ns / 1ps

module cfud_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_byte_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    // holding register may refill in the same cycle it is drained
    assign o_in_ready = !r_valid || i_take;
    assign n_valid    = (i_in_valid && o_in_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_byte_valid = r_valid;
    assign o_byte       = r_byte;

endmodule

// File: hdl/cfud_core.sv
`timescale 1ns / 1ps

module cfud_core
    import cfud_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [3:0] MaxLen = 4'(MAX_DATA_BYTES);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_STAMP = 3'd2,
        PH_IDENT = 3'd3,
        PH_FLAGS = 3'd4,
        PH_LEN   = 3'd5,
        PH_DATA  = 3'd6
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_cnt,    n_cnt;
    logic [63:0] r_stamp,  n_stamp;
    logic [31:0] r_ident,  n_ident;
    logic [1:0]  r_flags,  n_flags;
    logic [3:0]  r_len,    n_len;
    logic [63:0] r_data,   n_data;
    logic [3:0]  cnt_inc;
    logic        res_valid;
    logic        res_status;
    logic [63:0] res_data;

    assign cnt_inc = r_cnt + 4'd1;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_stamp    = r_stamp;
        n_ident    = r_ident;
        n_flags    = r_flags;
        n_len      = r_len;
        n_data     = r_data;
        res_valid  = 1'b0;
        res_status = STATUS_OK;
        res_data   = '0;
        case (r_phase)
            PH_HUNT2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_STAMP;
                    n_cnt   = '0;
                    n_stamp = '0;
                    n_ident = '0;
                    n_flags = '0;
                    n_len   = '0;
                    n_data  = '0;
                end else if (i_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_STAMP: begin
                n_stamp[{r_cnt[2:0], 3'b000} +: 8] =
                    r_stamp[{r_cnt[2:0], 3'b000} +: 8] | i_byte;
                n_cnt = cnt_inc;
                if (cnt_inc >= STAMP_BYTES) begin
                    n_cnt   = '0;
                    n_phase = PH_IDENT;
                end
            end
            PH_IDENT: begin
                n_ident[{r_cnt[1:0], 3'b000} +: 8] =
                    r_ident[{r_cnt[1:0], 3'b000} +: 8] | i_byte;
                n_cnt = cnt_inc;
                if (cnt_inc >= IDENT_BYTES) begin
                    n_cnt   = '0;
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                n_flags = i_byte[1:0];
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len = i_byte[3:0];
                n_cnt = '0;
                if (i_byte[3:0] > MaxLen) begin
                    res_valid  = 1'b1;
                    res_status = STATUS_BAD_LEN;
                    n_phase    = PH_HUNT1;
                end else if (i_byte[3:0] == 4'd0) begin
                    res_valid = 1'b1;
                    n_phase   = PH_HUNT1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_data[{r_cnt[2:0], 3'b000} +: 8] =
                    r_data[{r_cnt[2:0], 3'b000} +: 8] | i_byte;
                n_cnt = cnt_inc;
                if (cnt_inc >= r_len || cnt_inc >= LANE_LIMIT) begin
                    res_valid = 1'b1;
                    res_data  = n_data;
                    n_cnt     = '0;
                    n_phase   = PH_HUNT1;
                end
            end
            default: begin
                // hunting, unused codes land here too
                n_phase = (i_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_cnt   <= '0;
            r_stamp <= '0;
            r_ident <= '0;
            r_flags <= '0;
            r_len   <= '0;
            r_data  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_stamp <= n_stamp;
            r_ident <= n_ident;
            r_flags <= n_flags;
            r_len   <= n_len;
            r_data  <= n_data;
        end
    end

    assign o_res_valid          = res_valid;
    assign o_res.frame_status   = res_status;
    assign o_res.time_stamp     = r_stamp;
    assign o_res.identifier     = r_ident;
    assign o_res.remote_request = r_flags[0];
    assign o_res.extended_id    = r_flags[1];
    assign o_res.data_length    = n_len;
    assign o_res.payload        = res_data;

    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (r_phase == PH_LEN || r_phase == PH_DATA))
        else $error("result outside length or data phase");

    a_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res_valid) |=> (r_phase == PH_HUNT1))
        else $error("no return to hunting after result");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < LANE_LIMIT)
        else $error("byte count out of range");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_status == STATUS_BAD_LEN) |-> (res_data == '0))
        else $error("error result carries data");

endmodule

// File: hdl/cfud_out_stage.sv
`timescale 1ns / 1ps

module cfud_out_stage
    import cfud_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_slot_free,
    output logic    o_out_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
